[hw/rtl/lrupr_pkg.sv]
package lrupr_pkg;

   // Sizes of the frame table and of the fields.
   localparam int FRAMES     = 8;
   localparam int PAGE_BITS  = 16;
   localparam int SLOT_BITS  = 3;
   localparam int RANK_BITS  = 3;
   localparam int COUNT_BITS = 4;
   localparam int FAULT_BITS = 32;

   // Response word: hit, frame_slot, evicted_valid, evicted_page, fault_total.
   localparam int RSP_FIELD_BITS = 1 + SLOT_BITS + 1 + PAGE_BITS + FAULT_BITS;
   localparam int RSP_BITS       = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam logic [RANK_BITS-1:0]  RANK_MAX      = RANK_BITS'(FRAMES - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_RESET   = COUNT_BITS'(8);
   localparam logic [COUNT_BITS-1:0] COUNT_FRAMES  = COUNT_BITS'(FRAMES);
   localparam logic [FAULT_BITS-1:0] FAULT_MAX     = '1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_page;   // capture the incoming page number
      logic decide;      // register the lookup decision
      logic commit;      // update the frame table and load the response
      logic flush;       // take a new frame count and empty all frames
   } cmd_type;

endpackage

[hw/rtl/lru_page_replacement.sv]
// Flow: each request passes a lookup cycle and then a table update cycle,
// where the result is registered; the next request transfer is taken in the
// update cycle, and a stalled response holds off the update.
// Reset: synchronous, active high; all frames empty, frame count 8, fault
// counter zero. The frame pages themselves are not cleared.
module lru_page_replacement (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lrupr_pkg::PAGE_BITS-1:0]     req_tdata,   // [15:0] page_number
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] hit, [3:1] frame_slot, [4] evicted_valid, [20:5] evicted_page,
   // [52:21] fault_total, [55:53] zero
   output logic [lrupr_pkg::RSP_BITS-1:0]      rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lrupr_pkg::COUNT_BITS-1:0]    csr_data     // [3:0] frame_count
);
   import lrupr_pkg::*;

   cmd_type cmd;

   // The controller sequences each reference through a lookup cycle and an
   // update cycle. The next request transfer is taken in the update cycle.
   lrupr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // The datapath holds the frame table with recency ranks (zero is the most
   // recent) and the saturating fault counter. A frame count write empties
   // every frame but keeps the fault counter.
   lrupr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_page  (req_tdata),
      .csr_count (csr_data),
      .rsp_word  (rsp_tdata)
   );

endmodule

[hw/rtl/lrupr_ctrl.sv]
module lrupr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic               csr_valid,
   output logic               csr_ready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output lrupr_pkg::cmd_type cmd
);
   import lrupr_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (out_free) state_in = req_tvalid ? ST_LOOKUP : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      csr_ready  = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            csr_ready  = 1'b1;
         end
         ST_LOOKUP: begin
            cmd.decide = 1'b1;
         end
         ST_UPDATE: begin
            // The next item may enter as this one commits.
            req_tready = out_free;
            cmd.commit = out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
      cmd.load_page = req_tready && req_tvalid;
      cmd.flush     = csr_ready && csr_valid;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

[hw/rtl/lrupr_datapath.sv]
module lrupr_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  lrupr_pkg::cmd_type                 cmd,
   input  logic [lrupr_pkg::PAGE_BITS-1:0]    req_page,
   input  logic [lrupr_pkg::COUNT_BITS-1:0]   csr_count,
   output logic [lrupr_pkg::RSP_BITS-1:0]     rsp_word
);
   import lrupr_pkg::*;

   logic [PAGE_BITS-1:0]  page_ff, page_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [PAGE_BITS-1:0]  frame_page_ff [FRAMES];
   logic [PAGE_BITS-1:0]  frame_page_in [FRAMES];
   logic [FRAMES-1:0]     frame_valid_ff, frame_valid_in;
   logic [RANK_BITS-1:0]  frame_rank_ff [FRAMES];
   logic [RANK_BITS-1:0]  frame_rank_in [FRAMES];
   logic [FAULT_BITS-1:0] fault_ff, fault_in;

   // Registered decision of the lookup cycle.
   logic                  hit_ff, hit_in;
   logic [SLOT_BITS-1:0]  slot_ff, slot_in;
   logic                  evict_ff, evict_in;
   logic [PAGE_BITS-1:0]  evict_page_ff, evict_page_in;
   logic [RANK_BITS-1:0]  slot_rank_ff, slot_rank_in;

   logic [RSP_BITS-1:0]   rsp_ff, rsp_in;

   logic [FRAMES-1:0]     active;
   logic [COUNT_BITS-1:0] used;

   // Frame count zero acts as one frame, counts above the table as the table.
   always_comb begin
      if (count_ff == '0) begin
         used = COUNT_BITS'(1);
      end else if (count_ff > COUNT_FRAMES) begin
         used = COUNT_FRAMES;
      end else begin
         used = count_ff;
      end
      for (int k = 0; k < FRAMES; k++) begin
         active[k] = (5'(k) < 5'(used));
      end
   end

   // Lookup: first matching frame, else first empty frame, else oldest frame.
   always_comb begin
      logic                 found;
      logic                 empty;
      logic [SLOT_BITS-1:0] match_slot;
      logic [SLOT_BITS-1:0] empty_slot;
      logic [SLOT_BITS-1:0] old_slot;
      logic [RANK_BITS-1:0] best;
      found      = 1'b0;
      empty      = 1'b0;
      match_slot = '0;
      empty_slot = '0;
      old_slot   = '0;
      best       = '0;
      for (int k = 0; k < FRAMES; k++) begin
         if (!found && active[k] && frame_valid_ff[k] && frame_page_ff[k] == page_ff) begin
            found      = 1'b1;
            match_slot = SLOT_BITS'(k);
         end
         if (!empty && active[k] && !frame_valid_ff[k]) begin
            empty      = 1'b1;
            empty_slot = SLOT_BITS'(k);
         end
      end
      // Strict compare keeps the lowest index among equally old frames.
      for (int k = 0; k < FRAMES; k++) begin
         if (active[k] && frame_rank_ff[k] > best) begin
            best     = frame_rank_ff[k];
            old_slot = SLOT_BITS'(k);
         end
      end

      hit_in        = hit_ff;
      slot_in       = slot_ff;
      evict_in      = evict_ff;
      evict_page_in = evict_page_ff;
      slot_rank_in  = slot_rank_ff;
      if (cmd.decide) begin
         hit_in        = found;
         evict_in      = !found && !empty;
         evict_page_in = '0;
         if (found) begin
            slot_in = match_slot;
         end else if (empty) begin
            slot_in = empty_slot;
         end else begin
            slot_in       = old_slot;
            evict_page_in = frame_page_ff[old_slot];
         end
         slot_rank_in = frame_rank_ff[slot_in];
      end
   end

   // Update: chosen frame becomes most recent; younger (miss: all) age by one.
   always_comb begin
      logic [FAULT_BITS-1:0] fault_next;
      fault_next     = (fault_ff == FAULT_MAX) ? fault_ff : fault_ff + FAULT_BITS'(1);
      page_in        = cmd.load_page ? req_page : page_ff;
      count_in       = cmd.flush ? csr_count : count_ff;
      frame_valid_in = frame_valid_ff;
      fault_in       = fault_ff;
      rsp_in         = rsp_ff;
      for (int k = 0; k < FRAMES; k++) begin
         frame_page_in[k] = frame_page_ff[k];
         frame_rank_in[k] = frame_rank_ff[k];
      end
      if (cmd.flush) begin
         frame_valid_in = '0;
         for (int k = 0; k < FRAMES; k++) begin
            frame_rank_in[k] = '0;
         end
      end else if (cmd.commit) begin
         for (int k = 0; k < FRAMES; k++) begin
            if (SLOT_BITS'(k) != slot_ff && active[k] && frame_valid_ff[k]
                && (!hit_ff || frame_rank_ff[k] < slot_rank_ff)
                && frame_rank_ff[k] < RANK_MAX) begin
               frame_rank_in[k] = frame_rank_ff[k] + RANK_BITS'(1);
            end
         end
         frame_rank_in[slot_ff]  = '0;
         frame_valid_in[slot_ff] = 1'b1;
         if (!hit_ff) begin
            frame_page_in[slot_ff] = page_ff;
            fault_in               = fault_next;
         end
         rsp_in = RSP_BITS'({fault_in, evict_page_ff, evict_ff, slot_ff, hit_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= COUNT_RESET;
         frame_valid_ff <= '0;
         fault_ff       <= '0;
         for (int k = 0; k < FRAMES; k++) begin
            frame_rank_ff[k] <= '0;
         end
      end else begin
         count_ff       <= count_in;
         frame_valid_ff <= frame_valid_in;
         fault_ff       <= fault_in;
         for (int k = 0; k < FRAMES; k++) begin
            frame_rank_ff[k] <= frame_rank_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      page_ff       <= page_in;
      hit_ff        <= hit_in;
      slot_ff       <= slot_in;
      evict_ff      <= evict_in;
      evict_page_ff <= evict_page_in;
      slot_rank_ff  <= slot_rank_in;
      rsp_ff        <= rsp_in;
      for (int k = 0; k < FRAMES; k++) begin
         frame_page_ff[k] <= frame_page_in[k];
      end
   end

   assign rsp_word = rsp_ff;

endmodule

[hw/rtl/lrupr_checker.sv]
module lrupr_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [lrupr_pkg::RSP_BITS-1:0]      rsp_tdata,
   input logic                                csr_valid,
   input logic                                csr_ready
);
   import lrupr_pkg::*;

   // A stalled response keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // After a request transfer the lookup cycle takes neither a request nor a write.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready && !csr_ready)
      else $error("transfer accepted during lookup");

   // A hit never reports an eviction.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> !rsp_tdata[4] && rsp_tdata[20:5] == '0)
      else $error("hit reported with eviction");

   // Configuration is only taken while no reference is in progress, which is
   // when the block is also ready for a new request.
   assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |-> req_tready)
      else $error("configuration taken while a reference is in progress");

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready)
);

[verif/lru_page_replacement_checker.sv]
module lru_page_replacement_checker
   import lrupr_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [PAGE_BITS-1:0]       req_tdata,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [RSP_BITS-1:0]        rsp_tdata,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [COUNT_BITS-1:0]      csr_data,
   output int                         errors,
   output int                         pending,
   output int                         hits,
   output int                         evictions
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int POS_SLOT   = 1;
   localparam int POS_EVICT  = POS_SLOT + SLOT_BITS;
   localparam int POS_VICTIM = POS_EVICT + 1;
   localparam int POS_FAULTS = POS_VICTIM + PAGE_BITS;
   localparam int POS_PAD    = POS_FAULTS + FAULT_BITS;
   localparam int PRINT_CAP  = 40;

   typedef struct packed {
      logic                  hit;
      logic [SLOT_BITS-1:0]  slot;
      logic                  evicted;
      logic [PAGE_BITS-1:0]  victim;
      logic [FAULT_BITS-1:0] faults;
   } access_outcome_type;

   // Shadow copy of the frame table.
   logic [PAGE_BITS-1:0]  table_page [FRAMES];
   logic                  table_valid[FRAMES];
   logic [RANK_BITS-1:0]  table_age  [FRAMES];
   logic [FAULT_BITS-1:0] fault_tally;
   logic [COUNT_BITS-1:0] frames_cfg;

   access_outcome_type outcome_q[$];

   task automatic empty_table();
      for (int k = 0; k < FRAMES; k++) begin
         table_valid[k] = 1'b0;
         table_age[k]   = '0;
      end
   endtask

   function automatic int frames_in_use();
      if (frames_cfg == '0) return 1;
      if (frames_cfg > COUNT_FRAMES) return FRAMES;
      return int'(frames_cfg);
   endfunction

   // Frame x becomes the youngest; valid frames younger than limit grow one older.
   task automatic promote(input int n, input int x, input int limit);
      for (int k = 0; k < n; k++) begin
         if (k != x && table_valid[k] && int'(table_age[k]) < limit && table_age[k] < RANK_MAX)
            table_age[k] = table_age[k] + 1'b1;
      end
      table_age[x]   = '0;
      table_valid[x] = 1'b1;
   endtask

   task automatic lookup_page(input logic [PAGE_BITS-1:0] page,
                              output access_outcome_type res);
      int n;
      int slot;
      int oldest;
      bit found;
      bit has_empty;
      n = frames_in_use();
      slot = 0;
      found = 1'b0;
      has_empty = 1'b0;
      res = '0;
      for (int k = 0; k < n; k++) begin
         if (!found && table_valid[k] && table_page[k] == page) begin
            found = 1'b1;
            slot = k;
         end
      end
      if (found) begin
         promote(n, slot, int'(table_age[slot]));
      end else begin
         for (int k = 0; k < n; k++) begin
            if (!has_empty && !table_valid[k]) begin
               has_empty = 1'b1;
               slot = k;
            end
         end
         if (!has_empty) begin
            // Oldest frame goes; strict compare keeps the lowest index on a tie.
            oldest = 0;
            slot = 0;
            for (int k = 0; k < n; k++) begin
               if (int'(table_age[k]) > oldest) begin
                  oldest = int'(table_age[k]);
                  slot = k;
               end
            end
            res.evicted = 1'b1;
            res.victim  = table_page[slot];
         end
         promote(n, slot, FRAMES);
         table_page[slot] = page;
         if (fault_tally != FAULT_MAX) fault_tally = fault_tally + 1'b1;
      end
      res.hit    = found;
      res.slot   = SLOT_BITS'(slot);
      res.faults = fault_tally;
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      errors = errors + 1;
      if (errors <= PRINT_CAP)
         $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
   endtask

   always @(posedge clock) begin
      access_outcome_type want;
      access_outcome_type got;
      if (reset) begin
         empty_table();
         fault_tally = '0;
         frames_cfg  = COUNT_RESET;
         outcome_q.delete();
         errors    = 0;
         hits      = 0;
         evictions = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            frames_cfg = csr_data;
            empty_table();
         end
         if (req_tvalid && req_tready) begin
            lookup_page(req_tdata, want);
            if (want.hit) hits = hits + 1;
            if (want.evicted) evictions = evictions + 1;
            outcome_q.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.hit     = rsp_tdata[0];
            got.slot    = rsp_tdata[POS_SLOT +: SLOT_BITS];
            got.evicted = rsp_tdata[POS_EVICT];
            got.victim  = rsp_tdata[POS_VICTIM +: PAGE_BITS];
            got.faults  = rsp_tdata[POS_FAULTS +: FAULT_BITS];
            if (outcome_q.size() == 0) begin
               report_mismatch("response with no access outstanding", 64'(rsp_tdata), '0);
            end else begin
               want = outcome_q.pop_front();
               if (got.hit != want.hit)
                  report_mismatch("hit", 64'(got.hit), 64'(want.hit));
               if (got.slot != want.slot)
                  report_mismatch("frame_slot", 64'(got.slot), 64'(want.slot));
               if (got.evicted != want.evicted)
                  report_mismatch("evicted_valid", 64'(got.evicted), 64'(want.evicted));
               if (got.victim != want.victim)
                  report_mismatch("evicted_page", 64'(got.victim), 64'(want.victim));
               if (got.faults != want.faults)
                  report_mismatch("fault_total", 64'(got.faults), 64'(want.faults));
            end
            if (rsp_tdata[RSP_BITS-1:POS_PAD] != '0)
               report_mismatch("padding bits", 64'(rsp_tdata[RSP_BITS-1:POS_PAD]), '0);
         end
      end
      pending <= outcome_q.size();
   end

endmodule

[verif/tb.sv]
module tb;
   import lrupr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // The watchdog gives up after this many cycles without any transfer. The
   // slowest correct stretch is a long request gap plus a long response stall.
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASES         = 12;
   localparam int PHASE_ITEMS    = 65;
   localparam int HOT_MAX        = 12;

   logic clock;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [PAGE_BITS-1:0]   req_tdata = '0;    // [15:0] page_number
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [0] hit, [3:1] frame_slot, [4] evicted_valid, [20:5] evicted_page,
   // [52:21] fault_total, [55:53] zero
   logic [RSP_BITS-1:0]    rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [COUNT_BITS-1:0]  csr_data = '0;      // [3:0] frame_count

   int errors;
   int pending;
   int hits;
   int evictions;

   // Stimulus bookkeeping.
   bit                    steady = 1'b0;   // no idling on either side while set
   int                    stall_left = 0;
   int                    stall_cycles = 0;
   int                    items_sent = 0;
   int                    settings_done = 0;
   logic [PAGE_BITS-1:0]  last_page = '0;
   logic [PAGE_BITS-1:0]  hot_set[HOT_MAX];
   int                    hot_size = 1;

   lru_page_replacement DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   lru_page_replacement_checker scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .errors     (errors),
      .pending    (pending),
      .hits       (hits),
      .evictions  (evictions)
   );

   // A 4 ns clock.
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Idle length for either side: mostly none, often short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Response side back-pressure. Every stall decision is made at the clock
   // edge with a single nonblocking update of the ready line.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= pick_gap();
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog: counts cycles in which no channel completes a transfer.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired after %0d cycles without a transfer", stall_cycles);
         $display("FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Present one page reference and hold it until the block takes it. The
   // valid line is left high after the transfer so that back-to-back requests
   // never lower and raise it within one time step.
   task automatic send_page(input logic [PAGE_BITS-1:0] page);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= page;
      do @(posedge clock); while (!req_tready);
      last_page  = page;
      items_sent = items_sent + 1;
   endtask

   // Stop requesting and wait until every response has been taken. The
   // checker's outstanding count is registered, so the task waits on the clock
   // before it trusts that count.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Write a new frame count once the block is idle. This empties every frame.
   task automatic change_frames(input logic [COUNT_BITS-1:0] setting);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= setting;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      settings_done = settings_done + 1;
   endtask

   // Build a working set of the frames in use plus up to three pages, so that the
   // random references mix hits, fills and evictions.
   task automatic refresh_hot_set(input logic [COUNT_BITS-1:0] setting);
      int n;
      n = (setting == '0) ? 1 : ((setting > COUNT_FRAMES) ? FRAMES : int'(setting));
      hot_size = n + $urandom_range(0, 3);
      if (hot_size > HOT_MAX) hot_size = HOT_MAX;
      foreach (hot_set[i]) hot_set[i] = PAGE_BITS'($urandom);
   endtask

   function automatic logic [PAGE_BITS-1:0] pick_page();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return hot_set[$urandom_range(0, hot_size - 1)];
      if (r < 85) return last_page;
      if (r < 96) return PAGE_BITS'($urandom);
      return r[0] ? '1 : '0;
   endfunction

   initial begin
      logic [PAGE_BITS-1:0] warmup[17];
      logic [COUNT_BITS-1:0] plan[5];
      logic [COUNT_BITS-1:0] setting;

      warmup = '{16'h0000, 16'hFFFF, 16'h0000, 16'h0001, 16'h0002, 16'h0003,
                 16'h0004, 16'h0005, 16'h0006, 16'h0003, 16'h0007, 16'h0008,
                 16'hFFFF, 16'hFFFF, 16'h8000, 16'h0000, 16'h0002};
      plan = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd9};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part. With the reset count of eight frames: extreme page
      // numbers, filling the empty frames in order, hits on young and old
      // frames, and replacement of the oldest frame once all are full.
      steady = 1'b1;
      foreach (warmup[i]) send_page(warmup[i]);

      // A single frame: once it is filled, every miss replaces the one resident page.
      change_frames(4'd1);
      send_page(16'h0005);
      send_page(16'h0005);
      send_page(16'h0006);
      send_page(16'h0005);

      // A count of zero behaves as one frame.
      change_frames(4'd0);
      send_page(16'hAAAA);
      send_page(16'h5555);
      send_page(16'h5555);

      // Counts above the table size are clamped to the full table.
      change_frames(4'd15);

      // Random part: each phase picks a frame count, the extremes first, and
      // a fresh working set. Every fourth phase runs without idling.
      for (int p = 0; p < PHASES; p++) begin
         setting = (p < 5) ? plan[p] : COUNT_BITS'($urandom_range(0, 15));
         steady  = (p % 4 == 1);
         if (p > 0) change_frames(setting);
         else change_frames(setting);
         refresh_hot_set(setting);
         for (int i = 0; i < PHASE_ITEMS; i++) send_page(pick_page());
      end

      drain();
      repeat (8) @(posedge clock);

      $display("Covered %0d page references under %0d frame-count writes,",
               items_sent, settings_done);
      $display("with %0d hits and %0d evictions predicted.", hits, evictions);
      if (errors == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches, %0d responses missing", errors, pending);
         $display("FAIL");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/lrupr_pkg.sv
hw/rtl/lrupr_ctrl.sv
hw/rtl/lrupr_datapath.sv
hw/rtl/lru_page_replacement.sv
hw/rtl/lrupr_checker.sv
verif/lru_page_replacement_checker.sv
verif/tb.sv
